>>> hdl/qrs_pkg.sv
// Package for the quadratic root solver: word types, case codes and widths.
// Used by every module of the solver and by its checker.
package qrs_pkg;

	// Fixed field widths.
	localparam int COEF_W = 16;
	localparam int ROOT_W = 40;
	localparam int CODE_W = 3;

	// Default number of fraction bits of the roots.
	localparam int OUT_FRAC_BITS_DEF = 16;

	// Bit pairs of the square root beyond the fraction bits.
	localparam int SQRT_BASE_PAIRS = 17;

	// Numerator magnitude bits beyond the fraction bits.
	localparam int NUM_BASE_BITS = 18;

	// Divisor magnitude width: |2a| is at most 2^16.
	localparam int DMAG_W = 17;

	// Case codes.
	localparam logic [CODE_W-1:0] CASE_TWO     = 3'd0;
	localparam logic [CODE_W-1:0] CASE_DOUBLE  = 3'd1;
	localparam logic [CODE_W-1:0] CASE_NO_REAL = 3'd2;
	localparam logic [CODE_W-1:0] CASE_LINEAR  = 3'd3;
	localparam logic [CODE_W-1:0] CASE_NO_SOL  = 3'd4;
	localparam logic [CODE_W-1:0] CASE_ZERO    = 3'd5;

	// Input word.
	typedef struct packed {
		logic signed [COEF_W-1:0] coef_square;
		logic signed [COEF_W-1:0] coef_linear;
		logic signed [COEF_W-1:0] coef_constant;
	} coef_t;

	// Result word.
	typedef struct packed {
		logic [CODE_W-1:0]        case_code;
		logic signed [ROOT_W-1:0] root_first;
		logic signed [ROOT_W-1:0] root_second;
		logic                     saturated;
	} result_t;

	// Context carried along the square root chain.
	typedef struct packed {
		logic [CODE_W-1:0]        code;
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
	} ctx_t;

	// Context carried along the divider chain.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              neg1;
		logic              neg2;
	} div_side_t;

endpackage

>>> hdl/qrs_sqrt_cell.sv
// One cell of the restoring square root chain: handles one bit pair per word.
// Depends on qrs_pkg for the context type.
module qrs_sqrt_cell #(
	parameter int PAIRS = qrs_pkg::SQRT_BASE_PAIRS + qrs_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  qrs_pkg::ctx_t        ctx_in,
	input  logic [2*PAIRS-1:0]   rad_in,
	input  logic [PAIRS+1:0]     rem_in,
	input  logic [PAIRS-1:0]     root_in,
	output logic                 valid_q,
	output qrs_pkg::ctx_t        ctx_q,
	output logic [2*PAIRS-1:0]   rad_q,
	output logic [PAIRS+1:0]     rem_q,
	output logic [PAIRS-1:0]     root_q
);

	logic [PAIRS+3:0] rs;
	logic [PAIRS+3:0] tr;
	logic [PAIRS+3:0] diff;
	logic             ge;

	// Bring down the next pair and try to subtract 4*root+1.
	always_comb begin
		rs   = {rem_in, rad_in[2*PAIRS-1 -: 2]};
		tr   = {2'b00, root_in, 2'b01};
		diff = rs - tr;
		ge   = (rs >= tr);
	end

	// Valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q  <= ctx_in;
			rad_q  <= {rad_in[2*PAIRS-3:0], 2'b00};
			rem_q  <= ge ? diff[PAIRS+1:0] : rs[PAIRS+1:0];
			root_q <= {root_in[PAIRS-2:0], ge};
		end
	end

endmodule

>>> hdl/qrs_div_cell.sv
// One cell of the restoring divider chain: one quotient bit for each of two lanes.
// Depends on qrs_pkg for the side context type and the divisor width.
module qrs_div_cell #(
	parameter int NMW = qrs_pkg::NUM_BASE_BITS + qrs_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  qrs_pkg::div_side_t            side_in,
	input  logic [qrs_pkg::DMAG_W-1:0]    dmag_in,
	input  logic [qrs_pkg::DMAG_W-1:0]    rem1_in,
	input  logic [NMW-1:0]                qn1_in,
	input  logic [qrs_pkg::DMAG_W-1:0]    rem2_in,
	input  logic [NMW-1:0]                qn2_in,
	output logic                          valid_q,
	output qrs_pkg::div_side_t            side_q,
	output logic [qrs_pkg::DMAG_W-1:0]    dmag_q,
	output logic [qrs_pkg::DMAG_W-1:0]    rem1_q,
	output logic [NMW-1:0]                qn1_q,
	output logic [qrs_pkg::DMAG_W-1:0]    rem2_q,
	output logic [NMW-1:0]                qn2_q
);

	localparam int DW = qrs_pkg::DMAG_W;

	logic [DW:0] sh1, sh2, d1, d2, dv;
	logic        ge1, ge2;

	// Shift in the next numerator bit and compare against the divisor.
	always_comb begin
		dv  = {1'b0, dmag_in};
		sh1 = {rem1_in, qn1_in[NMW-1]};
		sh2 = {rem2_in, qn2_in[NMW-1]};
		ge1 = (sh1 >= dv);
		ge2 = (sh2 >= dv);
		d1  = sh1 - dv;
		d2  = sh2 - dv;
	end

	// Valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			dmag_q <= dmag_in;
			rem1_q <= ge1 ? d1[DW-1:0] : sh1[DW-1:0];
			rem2_q <= ge2 ? d2[DW-1:0] : sh2[DW-1:0];
			qn1_q  <= {qn1_in[NMW-2:0], ge1};
			qn2_q  <= {qn2_in[NMW-2:0], ge2};
		end
	end

endmodule

>>> hdl/quadratic_root_solver_top.sv
// Quadratic root solver, top level: discriminant front end, square root chain,
// divider chain and output buffer. Depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell.
//
// Solves a*x^2 + b*x + c = 0 for signed Q8.8 coefficients and returns a case code
// and the real roots in signed Q24.16 (the fraction width follows OUT_FRAC_BITS;
// the input fraction width cancels out). The block takes one word per cycle and
// keeps taking words while results wait in its two-entry output buffer. Each word
// passes the square root chain of 17 + OUT_FRAC_BITS cells and the divider chain
// of 18 + OUT_FRAC_BITS cells; the whole pipe stalls only when the buffer is full.
module quadratic_root_solver_top #(
	parameter int OUT_FRAC_BITS = qrs_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                coef_valid,
	output logic                coef_ready,
	input  qrs_pkg::coef_t      coef,
	output logic                result_valid,
	input  logic                result_ready,
	output qrs_pkg::result_t    result
);

	localparam int F     = OUT_FRAC_BITS;
	localparam int PAIRS = qrs_pkg::SQRT_BASE_PAIRS + F;
	localparam int RW    = 2 * PAIRS;
	localparam int NMW   = qrs_pkg::NUM_BASE_BITS + F;
	localparam int NW    = NMW + 1;
	localparam int DW    = qrs_pkg::DMAG_W;
	localparam int RTW   = qrs_pkg::ROOT_W;
	localparam int EW    = ((NW > RTW) ? NW : RTW) + 1;

	localparam logic signed [EW-1:0] ROOT_HI = EW'((64'sd1 <<< (RTW - 1)) - 64'sd1);
	localparam logic signed [EW-1:0] ROOT_LO = EW'(-(64'sd1 <<< (RTW - 1)));

	logic en;
	logic [1:0] cnt_q;

	// The pipe advances whenever the output buffer has room.
	assign en         = (cnt_q != 2'd2);
	assign coef_ready = en;

	// Stage 1: register the accepted word.
	logic           v_s1;
	qrs_pkg::coef_t coef_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= coef_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s1 <= coef;
		end
	end

	// Stage 2: products b*b and a*c, and the coarse case.
	logic                        v_s2;
	logic signed [31:0]          bb_s2, ac_s2;
	qrs_pkg::ctx_t               ctx_s2;
	logic signed [31:0]          a_w, b_w, c_w;
	logic [qrs_pkg::CODE_W-1:0]  code_n;

	always_comb begin
		a_w = 32'(coef_s1.coef_square);
		b_w = 32'(coef_s1.coef_linear);
		c_w = 32'(coef_s1.coef_constant);
		if (coef_s1.coef_square == '0 && coef_s1.coef_linear != '0) begin
			code_n = qrs_pkg::CASE_LINEAR;
		end else if (coef_s1.coef_square == '0 && coef_s1.coef_constant != '0) begin
			code_n = qrs_pkg::CASE_NO_SOL;
		end else if (coef_s1.coef_square == '0) begin
			code_n = qrs_pkg::CASE_ZERO;
		end else begin
			code_n = qrs_pkg::CASE_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s2       <= b_w * b_w;
			ac_s2       <= a_w * c_w;
			ctx_s2.code <= code_n;
			ctx_s2.a    <= coef_s1.coef_square;
			ctx_s2.b    <= coef_s1.coef_linear;
			ctx_s2.c    <= coef_s1.coef_constant;
		end
	end

	// Stage 3: discriminant, final case and the scaled radicand.
	logic                v_s3;
	qrs_pkg::ctx_t       ctx_s3;
	logic [RW-1:0]       rad_s3;
	logic signed [34:0]  disc;
	qrs_pkg::ctx_t       ctx_n;

	always_comb begin
		disc  = 35'(bb_s2) - (35'(ac_s2) <<< 2);
		ctx_n = ctx_s2;
		if (ctx_s2.code == qrs_pkg::CASE_TWO) begin
			if (disc == '0) begin
				ctx_n.code = qrs_pkg::CASE_DOUBLE;
			end else if (disc < 0) begin
				ctx_n.code = qrs_pkg::CASE_NO_REAL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3 <= ctx_n;
			if (ctx_s2.code == qrs_pkg::CASE_TWO && disc > 0) begin
				rad_s3 <= {disc[33:0], {(2*F){1'b0}}};
			end else begin
				rad_s3 <= '0;
			end
		end
	end

	// Square root chain, one bit pair per cell.
	logic          sv_c   [PAIRS+1];
	qrs_pkg::ctx_t sctx_c [PAIRS+1];
	logic [RW-1:0] rad_c  [PAIRS+1];
	logic [PAIRS+1:0] rem_c [PAIRS+1];
	logic [PAIRS-1:0] root_c [PAIRS+1];

	assign sv_c[0]   = v_s3;
	assign sctx_c[0] = ctx_s3;
	assign rad_c[0]  = rad_s3;
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar i = 0; i < PAIRS; i++) begin : g_sqrt
		qrs_sqrt_cell #(.PAIRS(PAIRS)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (sv_c[i]),
			.ctx_in   (sctx_c[i]),
			.rad_in   (rad_c[i]),
			.rem_in   (rem_c[i]),
			.root_in  (root_c[i]),
			.valid_q  (sv_c[i+1]),
			.ctx_q    (sctx_c[i+1]),
			.rad_q    (rad_c[i+1]),
			.rem_q    (rem_c[i+1]),
			.root_q   (root_c[i+1])
		);
	end

	// Numerator stage: -b*2^F +/- S over 2a, or -c*2^F over b.
	logic                        v_n;
	logic [qrs_pkg::CODE_W-1:0]  code_n2;
	logic signed [NW-1:0]        num1_n, num2_n;
	logic signed [DW:0]          den_n;
	qrs_pkg::ctx_t               cx;
	logic signed [NW-1:0]        bse, cse, sse;
	logic                        lin;

	always_comb begin
		cx  = sctx_c[PAIRS];
		lin = (cx.code == qrs_pkg::CASE_LINEAR);
		bse = -(NW'(cx.b) <<< F);
		cse = -(NW'(cx.c) <<< F);
		sse = $signed(NW'(root_c[PAIRS]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_n <= 1'b0;
		end else if (en) begin
			v_n <= sv_c[PAIRS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_n2 <= cx.code;
			num1_n  <= lin ? cse : (bse + sse);
			num2_n  <= lin ? cse : (bse - sse);
			den_n   <= lin ? (DW+1)'(cx.b) : ((DW+1)'(cx.a) <<< 1);
		end
	end

	// Magnitude stage: signs and magnitudes for the unsigned divider.
	logic               v_m;
	qrs_pkg::div_side_t side_m;
	logic [NMW-1:0]     mag1_m, mag2_m;
	logic [DW-1:0]      dmag_m;
	logic signed [NW-1:0] abs1, abs2;
	logic signed [DW:0]   absd;

	always_comb begin
		abs1 = num1_n[NW-1] ? -num1_n : num1_n;
		abs2 = num2_n[NW-1] ? -num2_n : num2_n;
		absd = den_n[DW] ? -den_n : den_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
		end else if (en) begin
			v_m <= v_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_m.code <= code_n2;
			side_m.neg1 <= num1_n[NW-1] ^ den_n[DW];
			side_m.neg2 <= num2_n[NW-1] ^ den_n[DW];
			mag1_m      <= abs1[NMW-1:0];
			mag2_m      <= abs2[NMW-1:0];
			dmag_m      <= absd[DW-1:0];
		end
	end

	// Divider chain, one quotient bit per cell in each lane.
	logic               dv_c   [NMW+1];
	qrs_pkg::div_side_t dside_c [NMW+1];
	logic [DW-1:0]      dmag_c [NMW+1];
	logic [DW-1:0]      rem1_c [NMW+1];
	logic [DW-1:0]      rem2_c [NMW+1];
	logic [NMW-1:0]     qn1_c  [NMW+1];
	logic [NMW-1:0]     qn2_c  [NMW+1];

	assign dv_c[0]    = v_m;
	assign dside_c[0] = side_m;
	assign dmag_c[0]  = dmag_m;
	assign rem1_c[0]  = '0;
	assign rem2_c[0]  = '0;
	assign qn1_c[0]   = mag1_m;
	assign qn2_c[0]   = mag2_m;

	for (genvar j = 0; j < NMW; j++) begin : g_div
		qrs_div_cell #(.NMW(NMW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (dv_c[j]),
			.side_in  (dside_c[j]),
			.dmag_in  (dmag_c[j]),
			.rem1_in  (rem1_c[j]),
			.qn1_in   (qn1_c[j]),
			.rem2_in  (rem2_c[j]),
			.qn2_in   (qn2_c[j]),
			.valid_q  (dv_c[j+1]),
			.side_q   (dside_c[j+1]),
			.dmag_q   (dmag_c[j+1]),
			.rem1_q   (rem1_c[j+1]),
			.qn1_q    (qn1_c[j+1]),
			.rem2_q   (rem2_c[j+1]),
			.qn2_q    (qn2_c[j+1])
		);
	end

	// Apply signs, clamp to the root range and zero the rootless cases.
	qrs_pkg::div_side_t fs;
	logic signed [EW-1:0] q1, q2, c1, c2;
	logic                 sat1, sat2, has_root;
	qrs_pkg::result_t     res_n;

	always_comb begin
		fs   = dside_c[NMW];
		q1   = $signed(EW'(qn1_c[NMW]));
		q2   = $signed(EW'(qn2_c[NMW]));
		if (fs.neg1) begin
			q1 = -q1;
		end
		if (fs.neg2) begin
			q2 = -q2;
		end
		sat1 = (q1 > ROOT_HI) || (q1 < ROOT_LO);
		sat2 = (q2 > ROOT_HI) || (q2 < ROOT_LO);
		c1   = (q1 > ROOT_HI) ? ROOT_HI : ((q1 < ROOT_LO) ? ROOT_LO : q1);
		c2   = (q2 > ROOT_HI) ? ROOT_HI : ((q2 < ROOT_LO) ? ROOT_LO : q2);
		has_root = (fs.code == qrs_pkg::CASE_TWO) || (fs.code == qrs_pkg::CASE_DOUBLE) ||
			(fs.code == qrs_pkg::CASE_LINEAR);
		res_n.case_code = fs.code;
		if (has_root) begin
			res_n.root_first  = c1[RTW-1:0];
			res_n.root_second = c2[RTW-1:0];
			res_n.saturated   = sat1 | sat2;
		end else begin
			res_n.root_first  = '0;
			res_n.root_second = '0;
			res_n.saturated   = 1'b0;
		end
	end

	// Two-entry output buffer.
	qrs_pkg::result_t buf_q [2];
	logic wptr_q, rptr_q;
	logic push, pop;

	assign push         = en && dv_c[NMW];
	assign pop          = result_valid && result_ready;
	assign result_valid = (cnt_q != 2'd0);
	assign result       = buf_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= res_n;
		end
	end

endmodule

>>> hdl/qrs_checker.sv
// Port-level checker for the quadratic root solver, bound to the top level.
// Depends on qrs_pkg and quadratic_root_solver_top.
module qrs_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_ready,
	input qrs_pkg::result_t result
);

	// A stalled result word holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result)))
		else $error("result word changed while stalled");

	// Case codes stay within the defined set.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.case_code <= qrs_pkg::CASE_ZERO))
		else $error("undefined case code");

	// Cases without roots give zero roots and no saturation.
	a_noroot: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.case_code == qrs_pkg::CASE_NO_REAL ||
			result.case_code == qrs_pkg::CASE_NO_SOL ||
			result.case_code == qrs_pkg::CASE_ZERO)) |->
		(result.root_first == '0 && result.root_second == '0 && !result.saturated))
		else $error("rootless case carries a root");

	// Single-root cases repeat the root.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.case_code == qrs_pkg::CASE_DOUBLE ||
			result.case_code == qrs_pkg::CASE_LINEAR)) |->
		(result.root_first == result.root_second))
		else $error("single root differs between fields");

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

>>> tb/sv/quadratic_root_solver_top_tb.sv
// Testbench for quadratic_root_solver_top: random and directed coefficient words,
// with a scoreboard class that predicts case code and roots. Depends on qrs_pkg.
`timescale 1ns / 100ps

module quadratic_root_solver_top_tb;

	localparam int FRAC = qrs_pkg::OUT_FRAC_BITS_DEF;
	localparam int LATENCY = 2 * FRAC + 40;
	localparam int WATCHDOG_LIMIT = 20 * LATENCY + 1000;
	localparam int N_RANDOM = 1300;

	// Root predictor and store of expected result words.
	class root_scoreboard;
		qrs_pkg::result_t pending_roots[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// Bit-serial floor(sqrt(d * 2^(2*FRAC))).
		function longint scaled_sqrt(longint d);
			longint rem, root, trial, pair;
			int k;
			rem = 0;
			root = 0;
			for (int i = qrs_pkg::SQRT_BASE_PAIRS + FRAC - 1; i >= 0; i--) begin
				k = 2 * i - 2 * FRAC;
				pair = (k >= 0) ? ((d >>> k) & 3) : 0;
				rem = (rem << 2) | pair;
				trial = (root << 2) | 1;
				if (rem >= trial) begin
					rem = rem - trial;
					root = (root << 1) | 1;
				end else begin
					root = root << 1;
				end
			end
			return root;
		endfunction

		// Clamp a quotient to the 40-bit root range.
		function longint clamp(longint q, inout bit sat);
			longint hi, lo;
			hi = (longint'(1) <<< (qrs_pkg::ROOT_W - 1)) - 1;
			lo = -(longint'(1) <<< (qrs_pkg::ROOT_W - 1));
			if (q > hi) begin
				sat = 1;
				return hi;
			end
			if (q < lo) begin
				sat = 1;
				return lo;
			end
			return q;
		endfunction

		// Note an accepted coefficient word and queue its expected result.
		function void note_coef(qrs_pkg::coef_t w);
			longint a, b, c, one, d, den, s, r1, r2;
			bit sat;
			qrs_pkg::result_t r;
			a = w.coef_square;
			b = w.coef_linear;
			c = w.coef_constant;
			one = longint'(1) <<< FRAC;
			r1 = 0;
			r2 = 0;
			sat = 0;
			if (a == 0 && b != 0) begin
				r.case_code = qrs_pkg::CASE_LINEAR;
				r1 = clamp((-c * one) / b, sat);
				r2 = r1;
			end else if (a == 0 && b == 0 && c != 0) begin
				r.case_code = qrs_pkg::CASE_NO_SOL;
			end else if (a == 0) begin
				r.case_code = qrs_pkg::CASE_ZERO;
			end else begin
				d = b * b - 4 * a * c;
				den = 2 * a;
				if (d > 0) begin
					s = scaled_sqrt(d);
					r.case_code = qrs_pkg::CASE_TWO;
					r1 = clamp((-b * one + s) / den, sat);
					r2 = clamp((-b * one - s) / den, sat);
				end else if (d == 0) begin
					r.case_code = qrs_pkg::CASE_DOUBLE;
					r1 = clamp((-b * one) / den, sat);
					r2 = r1;
				end else begin
					r.case_code = qrs_pkg::CASE_NO_REAL;
				end
			end
			r.root_first = r1[qrs_pkg::ROOT_W-1:0];
			r.root_second = r2[qrs_pkg::ROOT_W-1:0];
			r.saturated = sat;
			pending_roots.push_back(r);
		endfunction

		// Compare an accepted result word with the oldest expectation.
		function void check_result(qrs_pkg::result_t got);
			qrs_pkg::result_t exp_r;
			if (pending_roots.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending_roots.pop_front();
			if (got.case_code !== exp_r.case_code) begin
				$display("%0t: case_code expected %0d actual %0d", $time,
					exp_r.case_code, got.case_code);
				errors++;
			end
			if (got.root_first !== exp_r.root_first) begin
				$display("%0t: root_first expected %0d actual %0d", $time,
					exp_r.root_first, got.root_first);
				errors++;
			end
			if (got.root_second !== exp_r.root_second) begin
				$display("%0t: root_second expected %0d actual %0d", $time,
					exp_r.root_second, got.root_second);
				errors++;
			end
			if (got.saturated !== exp_r.saturated) begin
				$display("%0t: saturated expected %0d actual %0d", $time,
					exp_r.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic coef_valid = 0;
	logic coef_ready;
	qrs_pkg::coef_t coef = '0;
	logic result_valid;
	logic result_ready = 0;
	qrs_pkg::result_t result;

	root_scoreboard sb = new();
	bit stall_free = 0;
	int idle_cycles = 0;

	quadratic_root_solver_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.coef_valid(coef_valid),
		.coef_ready(coef_ready),
		.coef(coef),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #2 clk = ~clk;

	// Draw one coefficient: mostly random, sometimes an extreme or zero.
	function automatic logic [15:0] pick_coef();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'h8000;
			2: return 16'h7fff;
			3: return 16'(int'($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	// Send one coefficient word after a random gap, then hold until accepted.
	// Valid stays high after acceptance so that a word with no gap follows at once.
	task automatic send_coef(logic [15:0] a, logic [15:0] b, logic [15:0] c);
		int gap;
		gap = stall_free ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			coef_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		coef_valid <= 1;
		coef <= '{coef_square: a, coef_linear: b, coef_constant: c};
		do @(posedge clk); while (!coef_ready);
		sb.note_coef(coef);
	endtask

	// Stop sending and wait until every expected result has come.
	task automatic drain_coef();
		coef_valid <= 0;
		wait (sb.pending_roots.size() == 0);
		@(posedge clk);
	endtask

	// Result side: random stalls per word, checks on acceptance.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = stall_free ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				result_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1;
			do @(posedge clk); while (!result_valid);
			sb.check_result(result);
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if ((coef_valid && coef_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [15:0] a, b, c;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed words: every case code and extremes.
		send_coef(16'h0000, 16'h0000, 16'h0000);
		send_coef(16'h0000, 16'h0000, 16'h0100);
		send_coef(16'h0000, 16'h0000, 16'h8000);
		send_coef(16'h0000, 16'h0100, 16'h0200);
		send_coef(16'h0000, 16'h0001, 16'h8000);
		send_coef(16'h0000, 16'hffff, 16'h7fff);
		send_coef(16'h0000, 16'h8000, 16'h7fff);
		send_coef(16'h0100, 16'h0000, 16'hff00);
		send_coef(16'h0100, 16'hfe00, 16'h0100);
		send_coef(16'h0100, 16'h0000, 16'h0100);
		send_coef(16'h0001, 16'h7fff, 16'h0000);
		send_coef(16'h0001, 16'h8000, 16'h8000);
		send_coef(16'hffff, 16'h8000, 16'h7fff);
		send_coef(16'h8000, 16'h8000, 16'h8000);
		send_coef(16'h7fff, 16'h7fff, 16'h7fff);
		send_coef(16'h8000, 16'h0000, 16'h7fff);
		send_coef(16'h7fff, 16'h0000, 16'h8000);
		send_coef(16'h0001, 16'h0002, 16'h0001);
		send_coef(16'hffff, 16'h0001, 16'h0000);
		// Let the pipe drain before the random part.
		drain_coef();
		stall_free = 1;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2)
				stall_free = 0;
			if (i == N_RANDOM / 4)
				drain_coef();
			a = pick_coef();
			b = pick_coef();
			c = pick_coef();
			// Some exact double roots: b = 2k, a = 1, c = k*k.
			if ($urandom_range(0, 19) == 0) begin
				a = 16'd1;
				b = 16'($urandom_range(0, 180) * 2);
				c = 16'((b / 2) * (b / 2));
			end
			send_coef(a, b, c);
		end
		drain_coef();
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_roots.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
